FILE: design/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial chain value, rotate and message schedule helper
// functions, and the transaction type carried from the front end to the back end.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } sha_item_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: design/sha_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA item queue
// Short FIFO that parts the front end from the compression back end.
// ----------------------------------------------------------------------------
module sha_queue import sha_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  sha_item_t wr_item,
  output logic      full,
  input  logic      rd_en,
  output sha_item_t rd_item,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_item;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full)
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en && !empty)
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

endmodule

FILE: design/sha_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 back end
// Absorbs bytes into the block buffer, pads, runs 64 rounds per block and
// delivers the eight digest words from the chain value register.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  sha_item_t   item,
  output logic        item_take,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]  state_r;
  logic [31:0] wbuf_r [16];
  logic [5:0]  fill_r;
  logic [63:0] len_r, tot_r;
  logic        fin_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [5:0]  rnd_r;
  logic [2:0]  widx_r;
  logic        ov_r;
  logic        pad_mark_r;
  logic        zero_tail_r;
  logic        len_in_r;

  logic        byte_go, blk_full;
  logic [7:0]  pad_byte;
  logic [31:0] w_cur, w_new, t1, t2;

  // padding byte for the current offset: marker, zeros, then the length
  always_comb begin
    if (pad_mark_r) pad_byte = PAD_BYTE;
    else if (fill_r < LEN_OFFSET || zero_tail_r) pad_byte = 8'h00;
    else pad_byte = tot_r[8'(7 - 32'(fill_r[2:0])) * 8 +: 8];
  end

  assign item_take = item_valid && (state_r == S_IDLE);
  assign byte_go   = (item_take && item.present) || (state_r == S_PAD);
  assign blk_full  = (fill_r == 6'd63);

  // round datapath; the schedule rotates through wbuf
  assign w_cur = wbuf_r[0];
  assign w_new = sig1(wbuf_r[14]) + wbuf_r[9] + sig0(wbuf_r[1]) + wbuf_r[0];
  assign t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25)) +
              ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + ROUND_K[rnd_r] + w_cur;
  assign t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22)) +
              ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign out_empty       = !ov_r;
  assign out_digest_word = h_r[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 3'd7);

  // byte loading into the word buffer, and schedule shifting during rounds
  always_ff @(posedge clk) begin
    logic [7:0] b;
    b = (state_r == S_PAD) ? pad_byte : item.data;
    if (byte_go)
      wbuf_r[fill_r[5:2]][8'(3 - 32'(fill_r[1:0])) * 8 +: 8] <= b;
    else if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) wbuf_r[i] <= wbuf_r[i+1];
      wbuf_r[15] <= w_new;
    end
  end

  // control, chain value and working variables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      fin_r       <= 1'b0;
      rnd_r       <= '0;
      widx_r      <= '0;
      ov_r        <= 1'b0;
      pad_mark_r  <= 1'b0;
      zero_tail_r <= 1'b0;
      len_in_r    <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      case (state_r)
        S_IDLE: begin
          if (item_take) begin
            if (item.present) len_r <= len_r + 64'd8;
            if (item.eom) begin
              fin_r      <= 1'b1;
              pad_mark_r <= 1'b1;
              tot_r      <= len_r + (item.present ? 64'd8 : 64'd0);
            end
            if (item.present) begin
              fill_r <= fill_r + 1'b1;
              if (blk_full) begin
                state_r <= S_ROUND;
                rnd_r   <= '0;
                for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              end else if (item.eom) state_r <= S_PAD;
            end else if (item.eom) state_r <= S_PAD;
          end
        end
        S_PAD: begin
          fill_r     <= fill_r + 1'b1;
          pad_mark_r <= 1'b0;
          // marker in the last eight bytes: the length needs a further block
          if (blk_full) zero_tail_r <= 1'b0;
          else if (pad_mark_r && fill_r >= LEN_OFFSET) zero_tail_r <= 1'b1;
          if (blk_full && !pad_mark_r && !zero_tail_r) len_in_r <= 1'b1;
          if (blk_full) begin
            state_r <= S_ROUND;
            rnd_r   <= '0;
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
        S_ROUND: begin
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (fin_r && len_in_r) begin
            state_r <= S_EMIT;
            widx_r  <= '0;
            ov_r    <= 1'b1;
          end else if (fin_r) state_r <= S_PAD;
          else state_r <= S_IDLE;
        end
        S_EMIT: begin
          if (out_pop) begin
            widx_r <= widx_r + 1'b1;
            if (widx_r == 3'd7) begin
              ov_r     <= 1'b0;
              state_r  <= S_IDLE;
              fin_r    <= 1'b0;
              len_in_r <= 1'b0;
              len_r    <= '0;
              fill_r   <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/sha256_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-fed SHA-256 hash with queue-style input and result channels.
// ----------------------------------------------------------------------------
// Input: push a byte with byte_present and end_of_message flags while full is
// low. A short queue holds items while the back end compresses a block.
// The back end loads each byte into its block buffer; each full 64-byte
// block then runs the rounds and a fold in the single round unit, and no
// new byte is taken until that fold is done.
// On end_of_message the back end pads one byte per cycle (one or two blocks),
// compresses each padding block the same way and offers the eight digest
// words, word 0 first, on the out_ ports once the last fold is done, while
// empty is low; each pop takes one word. A stalled receiver holds the
// digest; the queue keeps taking items until it fills.
// After the eighth word the chain value returns to the initial constants.
// Reset (rst_n low, synchronous) clears the queue, the length and the fill
// count, and returns the chain value to the initial constants.
// ----------------------------------------------------------------------------
module sha256_message_digest import sha_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_item_t wr_item, rd_item;
  logic      q_empty, take;

  // drop byte-less items that do not end a message
  assign wr_item = '{data: in_msg_byte, present: in_byte_present, eom: in_end_of_message};

  sha_queue #(.DEPTH(DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_en   (push && (in_byte_present || in_end_of_message)),
    .wr_item (wr_item),
    .full    (full),
    .rd_en   (take),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  sha_core u_core (
    .clk, .rst_n,
    .item_valid      (!q_empty),
    .item            (rd_item),
    .item_take       (take),
    .out_empty       (empty),
    .out_pop         (pop),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
